/* design/receive_seq_window_tracker_assert.svh */
// assertion macros used by the sequence window tracker window module (rswt_window)
`ifndef RECEIVE_SEQ_WINDOW_TRACKER_ASSERT_SVH
`define RECEIVE_SEQ_WINDOW_TRACKER_ASSERT_SVH

`ifndef SYNTHESIS
// property holds at every clock edge out of reset
`define RSWT_ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rswt assertion failed");
// consequent holds in the cycle after the antecedent
`define RSWT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rswt assertion failed");
`else
`define RSWT_ASSERT_ALWAYS(label, clk, rst_n, prop)
`define RSWT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* design/rswt_pkg.sv */
// types and constants of the receive sequence window tracker
package rswt_pkg;

    localparam int unsigned SeqW   = 64;
    localparam int unsigned LowW   = 16;
    localparam int unsigned DiffW  = 17;
    localparam int unsigned SpanW  = 6;

    localparam logic [SeqW-1:0]  TopBit     = {1'b1, {(SeqW-1){1'b0}}};
    localparam logic [SeqW-1:0]  AllOnes    = {SeqW{1'b1}};
    localparam logic [LowW-1:0]  ExtendBack = 16'h4000;
    localparam logic signed [DiffW-1:0] SpanPos = 17'sd64;
    localparam logic signed [DiffW-1:0] SpanNeg = -17'sd64;
    localparam logic signed [DiffW-1:0] DiffOne = 17'sd1;

    // item verdicts
    typedef enum logic [2:0] {
        VERDICT_ADVANCE = 3'd0,
        VERDICT_JUMP    = 3'd1,
        VERDICT_FILLED  = 3'd2,
        VERDICT_DUP     = 3'd3,
        VERDICT_TOO_OLD = 3'd4,
        VERDICT_RESET   = 3'd5
    } t_verdict;

    // operation selector
    localparam logic OP_RECEIVE = 1'b0;
    localparam logic OP_RESET   = 1'b1;

    typedef struct packed {
        logic            operation;
        logic [LowW-1:0] seq_low;
        logic [SeqW-1:0] new_head;
    } t_item;

    typedef struct packed {
        logic            accepted;
        t_verdict        verdict;
        logic [SeqW-1:0] full_seqno;
        logic [LowW-1:0] ack_seq_low;
        logic [LowW-1:0] ack_vector;
    } t_result;

endpackage

/* design/rswt_window.sv */
// head and bitmap state with the per-word window update
`include "receive_seq_window_tracker_assert.svh"

module rswt_window (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  rswt_pkg::t_item  i_item,
    output rswt_pkg::t_result o_result
);

    logic [rswt_pkg::SeqW-1:0]         r_head;
    logic [rswt_pkg::SeqW-1:0]         r_bitmap;
    logic [rswt_pkg::SeqW-1:0]         n_head;
    logic [rswt_pkg::SeqW-1:0]         n_bitmap;
    logic [rswt_pkg::LowW-1:0]         seq_delta;
    logic signed [rswt_pkg::DiffW-1:0] diff;
    logic [rswt_pkg::SeqW-1:0]         full;
    logic [rswt_pkg::SpanW-1:0]        fill_pos;
    logic [rswt_pkg::SeqW-1:0]         fill_bit;
    logic                              drop_fire;
    logic                              jump_fire;
    logic                              reset_fire;

    // distance of the extended number from head, from -16384 to +49151
    assign seq_delta = i_item.seq_low - r_head[rswt_pkg::LowW-1:0] + rswt_pkg::ExtendBack;
    assign diff      = $signed({1'b0, seq_delta}) - $signed({1'b0, rswt_pkg::ExtendBack});
    assign full      = r_head + {{(rswt_pkg::SeqW-rswt_pkg::DiffW){diff[rswt_pkg::DiffW-1]}},
                                 diff};
    assign fill_pos  = diff[rswt_pkg::SpanW-1:0] - rswt_pkg::SpanW'(1);
    assign fill_bit  = rswt_pkg::SeqW'(1) << fill_pos;

    // verdict and next state
    always_comb begin
        n_head              = r_head;
        n_bitmap            = r_bitmap;
        o_result.accepted   = 1'b0;
        o_result.verdict    = rswt_pkg::VERDICT_DUP;
        o_result.full_seqno = full;
        if (i_item.operation == rswt_pkg::OP_RESET) begin
            n_head              = i_item.new_head;
            n_bitmap            = rswt_pkg::AllOnes;
            o_result.accepted   = 1'b1;
            o_result.verdict    = rswt_pkg::VERDICT_RESET;
            o_result.full_seqno = '0;
        end else if (diff >= rswt_pkg::SpanPos) begin
            n_head            = full;
            n_bitmap          = rswt_pkg::TopBit;
            o_result.accepted = 1'b1;
            o_result.verdict  = rswt_pkg::VERDICT_JUMP;
        end else if (diff >= rswt_pkg::DiffOne) begin
            n_head            = full;
            n_bitmap          = (r_bitmap >> diff[rswt_pkg::SpanW-1:0]) | rswt_pkg::TopBit;
            o_result.accepted = 1'b1;
            o_result.verdict  = rswt_pkg::VERDICT_ADVANCE;
        end else if (diff <= rswt_pkg::SpanNeg) begin
            o_result.verdict = rswt_pkg::VERDICT_TOO_OLD;
        end else if ((r_bitmap & fill_bit) != '0) begin
            o_result.verdict = rswt_pkg::VERDICT_DUP;
        end else begin
            n_bitmap          = r_bitmap | fill_bit;
            o_result.accepted = 1'b1;
            o_result.verdict  = rswt_pkg::VERDICT_FILLED;
        end
        // acknowledgement summary after the step
        o_result.ack_seq_low = n_head[rswt_pkg::LowW-1:0];
        o_result.ack_vector  = {&n_bitmap[47:0], n_bitmap[62:48]};
    end

    // window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_bitmap <= rswt_pkg::AllOnes;
        end else if (i_fire) begin
            r_head   <= n_head;
            r_bitmap <= n_bitmap;
        end
    end

    // word kinds seen by the checks
    assign drop_fire  = i_fire && !o_result.accepted;
    assign jump_fire  = i_fire && o_result.verdict == rswt_pkg::VERDICT_JUMP;
    assign reset_fire = i_fire && i_item.operation == rswt_pkg::OP_RESET;

    // head position is always marked received
    `RSWT_ASSERT_ALWAYS(a_head_bit_set, i_clk, i_rst_n, r_bitmap[rswt_pkg::SeqW-1])
    // a dropped word leaves the window untouched
    `RSWT_ASSERT_NEXT(a_drop_keeps_state, i_clk, i_rst_n, drop_fire, $stable({r_head, r_bitmap}))
    // a jump leaves only the head bit
    `RSWT_ASSERT_NEXT(a_jump_bitmap, i_clk, i_rst_n, jump_fire, r_bitmap == rswt_pkg::TopBit)
    // a reset word loads its head
    `RSWT_ASSERT_NEXT(a_reset_head, i_clk, i_rst_n, reset_fire, r_head == $past(i_item.new_head))
    // a reset word fills the window
    `RSWT_ASSERT_NEXT(a_reset_fill, i_clk, i_rst_n, reset_fire, r_bitmap == rswt_pkg::AllOnes)

endmodule

/* design/receive_seq_window_tracker.sv */
// receive sequence window tracker: input register, window update, result register
// throughput: one word per cycle while the output is not held by tready; the head/bitmap update is combinational
// the output register lets a new word enter while a result waits for tready
// reset (synchronous, active low): head 0, bitmap all ones, both stages empty
// no clearing pass; the block takes words in the first cycle after reset

module receive_seq_window_tracker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [79:0]   i_s_axis_tdata,   // seq_low[15:0], new_head[79:16]
    input  logic          i_s_axis_tuser,   // operation[0]
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [103:0]  o_m_axis_tdata    // accepted[0], verdict[3:1], full_seqno[67:4],
                                            // ack_seq_low[83:68], ack_vector[99:84], zero
);

    logic              r_in_valid;
    rswt_pkg::t_item   r_in;
    logic              r_out_valid;
    rswt_pkg::t_result r_out;
    logic              fire;
    logic              in_take;
    rswt_pkg::t_result result;

    // advance when the result register is free or being drained
    assign fire            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || fire;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.operation <= i_s_axis_tuser;
            r_in.seq_low   <= i_s_axis_tdata[15:0];
            r_in.new_head  <= i_s_axis_tdata[79:16];
        end
    end

    rswt_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .o_result (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    // output word packing
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out.ack_vector, r_out.ack_seq_low, r_out.full_seqno,
                              r_out.verdict, r_out.accepted};

endmodule
